>>> rtl/tpz_pkg.sv
package tpz_pkg;

    localparam int MUL_A_W     = 34;
    localparam int MUL_B_W     = 25;
    localparam int ACC_W       = 64;
    localparam int DEN_W       = 50;
    localparam int TMP_W       = 34;
    localparam int PROD_W      = 32;
    localparam int POS_W       = 22;
    localparam int TRIG_W      = 16;
    localparam int HALF_W      = 18;
    localparam int DEPTH_W     = 16;
    localparam int SHADE_W     = 4;
    localparam int GLYPH_W     = 8;
    localparam int SCALE_W     = 8;
    localparam int SCALED_W    = 24;
    localparam int STEP_W      = 4;
    localparam int CFG_AW      = 5;
    localparam int CFG_DW      = 32;

    localparam int FRAC_BITS     = 14;
    localparam int TUBE_OFFSET   = 2;
    localparam int PERSP_OFFSET  = 5;
    localparam int DEN_SHIFT     = 42;
    localparam int ROT_SHIFT     = 28;
    localparam int CENTER_SHIFT  = 29;
    localparam int SCREEN_SHIFT  = 30;
    localparam int LIGHT_SCALE   = 8;
    localparam int LUM_SHIFT     = DEN_SHIFT - $clog2(LIGHT_SCALE);
    localparam int MAX_LIGHT     = 11;
    localparam int RECIP_BITS    = 16;

    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MATH,
        S_DIV,
        S_PROJ,
        S_READ,
        S_UPDATE
    } t_state;

    typedef enum logic [2:0] {
        REG_SIN_ROT_A,
        REG_COS_ROT_A,
        REG_SIN_ROT_B,
        REG_COS_ROT_B,
        REG_SCALE_HORIZ,
        REG_SCALE_VERT
    } t_reg;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [SHADE_W-1:0] shade;
    } t_cell;

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [SHADE_W-1:0] s);
        logic [GLYPH_W-1:0] g;
        case (s)
            4'd1:    g = 8'h2E;
            4'd2:    g = 8'h2C;
            4'd3:    g = 8'h2D;
            4'd4:    g = 8'h7E;
            4'd5:    g = 8'h3A;
            4'd6:    g = 8'h3B;
            4'd7:    g = 8'h3D;
            4'd8:    g = 8'h21;
            4'd9:    g = 8'h2A;
            4'd10:   g = 8'h23;
            4'd11:   g = 8'h24;
            4'd12:   g = 8'h40;
            default: g = GLYPH_SPACE;
        endcase
        return g;
    endfunction

endpackage

>>> rtl/tpz_ram.sv
module tpz_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 3200
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/torus_point_zbuffer_plot_core.sv
// torus point plotter with a depth-tested glyph store of COLUMNS x ROWS cells
// request channel: i_valid / o_stall, taken when i_valid is high and o_stall low
//   i_cmd low: plot one torus point given by tube and ring sines and cosines
//   i_cmd high: read the glyph of cell i_cell_index and clear that cell
// result channel: o_valid / i_stall, one glyph per read request, none for a plot
// a plot runs the math steps on the shared multiplier, then the reciprocal
//   divider unless the depth saturates, then the projection steps and, when
//   the point lands on screen, the store read and update; a point off screen
//   ends after projection, a dropped point after the math steps
// a read reads the store, then registers its glyph in the output register
// one request is in flight at a time; o_stall is high until it is done
// the output register holds a glyph while i_stall is high; a following
//   request is taken, and a second read waits in its store cycle until
//   the output register is free
// reset (i_rst_n low, synchronous) loads the register defaults and then
//   clears the store, one cell per cycle, COLUMNS*ROWS cells (3200 by default)
//   with o_stall high; the apb port works throughout
module torus_point_zbuffer_plot_core
    import tpz_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 40
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_cmd,
    input  logic signed [TRIG_W-1:0] i_sin_tube,
    input  logic signed [TRIG_W-1:0] i_cos_tube,
    input  logic signed [TRIG_W-1:0] i_sin_ring,
    input  logic signed [TRIG_W-1:0] i_cos_ring,
    input  logic [11:0]              i_cell_index,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [GLYPH_W-1:0]       o_glyph,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_AW-1:0]        paddr,
    input  logic [CFG_DW-1:0]        pwdata,
    output logic [CFG_DW-1:0]        prdata,
    output logic                     pready
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(COLUMNS);
    localparam int YW    = $clog2(ROWS);
    localparam int IW    = (AW > 12) ? AW : 12;
    localparam int CELL_W = DEPTH_W + SHADE_W;

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic [AW-1:0]     r_clr;

    logic signed [TRIG_W-1:0] r_sin_a, r_cos_a, r_sin_b, r_cos_b;
    logic [SCALE_W-1:0]       r_scale_h, r_scale_v;

    logic                      r_cmd;
    logic signed [TRIG_W-1:0]  r_st, r_ct, r_sr, r_cr;
    logic signed [HALF_W-1:0]  r_h;
    logic signed [TMP_W-1:0]   r_ta, r_te, r_t;
    logic signed [PROD_W-1:0]  r_tb, r_tc;
    logic signed [ACC_W-1:0]   r_acc, r_xs, r_ys;
    logic signed [DEN_W-1:0]   r_den;
    logic signed [POS_W-1:0]   r_px, r_py;
    logic [DEN_W-1:0]          r_rem;
    logic [DEPTH_W-1:0]        r_d;
    logic [SCALED_W-1:0]       r_sd;
    logic [SHADE_W-1:0]        r_shade;
    logic [AW-1:0]             r_addr;
    logic                      r_inrange;
    logic                      r_ovalid;
    logic [GLYPH_W-1:0]        r_oglyph;

    logic signed [MUL_A_W-1:0]         mul_a;
    logic signed [MUL_B_W-1:0]         mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;
    logic signed [ACC_W-1:0]           p64, alu, lum;
    logic [SHADE_W-1:0]                shade_n;
    logic [DEN_W-1:0]                  rem2;
    logic                              div_ge;
    logic                              accept, cfg_we, out_free;
    logic                              x_ok, y_ok, hit;
    logic [XW-1:0]                     pos_x;
    logic [YW-1:0]                     pos_y;
    logic [IW-1:0]                     idx_ext;
    logic                              ram_we, ram_re;
    logic [AW-1:0]                     ram_waddr;
    t_cell                             ram_wdata, ram_rdata;
    logic [CELL_W-1:0]                 ram_rword;

    assign accept   = i_valid && !o_stall;
    assign cfg_we   = psel && penable && pwrite && pready;
    assign out_free = !r_ovalid || !i_stall;
    assign pready   = 1'b1;
    assign idx_ext  = IW'(i_cell_index);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin_a   <= '0;
            r_cos_a   <= 16'sd16384;
            r_sin_b   <= '0;
            r_cos_b   <= 16'sd16384;
            r_scale_h <= 8'd40;
            r_scale_v <= 8'd20;
        end else if (cfg_we) begin
            case (t_reg'(paddr[4:2]))
                REG_SIN_ROT_A:   r_sin_a   <= pwdata[TRIG_W-1:0];
                REG_COS_ROT_A:   r_cos_a   <= pwdata[TRIG_W-1:0];
                REG_SIN_ROT_B:   r_sin_b   <= pwdata[TRIG_W-1:0];
                REG_COS_ROT_B:   r_cos_b   <= pwdata[TRIG_W-1:0];
                REG_SCALE_HORIZ: r_scale_h <= pwdata[SCALE_W-1:0];
                REG_SCALE_VERT:  r_scale_v <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg'(paddr[4:2]))
            REG_SIN_ROT_A:   prdata = {16'b0, r_sin_a};
            REG_COS_ROT_A:   prdata = {16'b0, r_cos_a};
            REG_SIN_ROT_B:   prdata = {16'b0, r_sin_b};
            REG_COS_ROT_B:   prdata = {16'b0, r_cos_b};
            REG_SCALE_HORIZ: prdata = {24'b0, r_scale_h};
            REG_SCALE_VERT:  prdata = {24'b0, r_scale_v};
            default:         prdata = '0;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MATH: begin
                case (r_step)
                    4'd0:    begin mul_a = MUL_A_W'(r_sr); mul_b = MUL_B_W'(r_h);     end
                    4'd1:    begin mul_a = MUL_A_W'(r_st); mul_b = MUL_B_W'(r_cos_a); end
                    4'd2:    begin mul_a = MUL_A_W'(r_st); mul_b = MUL_B_W'(r_sin_a); end
                    4'd3:    begin mul_a = r_ta;           mul_b = MUL_B_W'(r_sin_a); end
                    4'd4:    begin mul_a = r_ta;           mul_b = MUL_B_W'(r_cos_a); end
                    4'd5:    begin mul_a = MUL_A_W'(r_cr); mul_b = MUL_B_W'(r_h);     end
                    4'd6:    begin mul_a = r_te;           mul_b = MUL_B_W'(r_cos_b); end
                    4'd7:    begin mul_a = r_t;            mul_b = MUL_B_W'(r_sin_b); end
                    4'd8:    begin mul_a = r_te;           mul_b = MUL_B_W'(r_sin_b); end
                    4'd9:    begin mul_a = r_t;            mul_b = MUL_B_W'(r_cos_b); end
                    4'd10:   begin mul_a = MUL_A_W'(r_sr); mul_b = MUL_B_W'(r_ct);    end
                    4'd11:   begin mul_a = r_ta;           mul_b = MUL_B_W'(r_cos_a); end
                    4'd12:   begin mul_a = r_t;            mul_b = MUL_B_W'(r_cos_b); end
                    4'd13:   begin mul_a = r_ta;           mul_b = MUL_B_W'(r_sin_a); end
                    4'd14:   begin mul_a = MUL_A_W'(r_cr); mul_b = MUL_B_W'(r_ct);    end
                    default: begin mul_a = r_te;           mul_b = MUL_B_W'(r_sin_b); end
                endcase
            end
            S_PROJ: begin
                case (r_step)
                    4'd0: begin
                        mul_a = MUL_A_W'($signed({1'b0, r_d}));
                        mul_b = MUL_B_W'($signed({1'b0, r_scale_h}));
                    end
                    4'd1: begin
                        mul_a = MUL_A_W'(r_px);
                        mul_b = MUL_B_W'($signed({1'b0, r_sd}));
                    end
                    4'd2: begin
                        mul_a = MUL_A_W'($signed({1'b0, r_d}));
                        mul_b = MUL_B_W'($signed({1'b0, r_scale_v}));
                    end
                    4'd3: begin
                        mul_a = MUL_A_W'(r_py);
                        mul_b = MUL_B_W'($signed({1'b0, r_sd}));
                    end
                    default: begin
                        mul_a = MUL_A_W'($signed({1'b0, pos_y}));
                        mul_b = MUL_B_W'(COLUMNS);
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign p64   = ACC_W'(mul_p);

    // adder after the multiplier
    always_comb begin
        alu = p64;
        case (r_state)
            S_MATH: begin
                case (r_step)
                    4'd3:  alu = p64 + (ACC_W'(r_tb) <<< FRAC_BITS)
                                 + (ACC_W'(PERSP_OFFSET) <<< DEN_SHIFT);
                    4'd4:  alu = (p64 - (ACC_W'(r_tc) <<< FRAC_BITS)) >>> FRAC_BITS;
                    4'd7:  alu = (r_acc - p64) >>> ROT_SHIFT;
                    4'd9:  alu = (r_acc + p64) >>> ROT_SHIFT;
                    4'd11: alu = ((ACC_W'(r_tc) <<< FRAC_BITS) - p64) >>> FRAC_BITS;
                    4'd12: alu = p64 - (ACC_W'(r_tb) <<< FRAC_BITS);
                    4'd13: alu = r_acc - p64;
                    4'd15: alu = r_acc - p64;
                    default: alu = p64;
                endcase
            end
            S_PROJ: begin
                case (r_step)
                    4'd1:    alu = (ACC_W'(COLUMNS) <<< CENTER_SHIFT) + p64;
                    4'd3:    alu = (ACC_W'(ROWS) <<< CENTER_SHIFT) + p64;
                    default: alu = p64;
                endcase
            end
            default: ;
        endcase
    end

    // lighting index, clamped, plus one
    assign lum = alu;
    always_comb begin
        if (lum[ACC_W-1]) begin
            shade_n = SHADE_W'(1);
        end else if ((|lum[ACC_W-1:LUM_SHIFT+SHADE_W])
                     || (lum[LUM_SHIFT +: SHADE_W] > SHADE_W'(MAX_LIGHT))) begin
            shade_n = SHADE_W'(MAX_LIGHT + 1);
        end else begin
            shade_n = lum[LUM_SHIFT +: SHADE_W] + SHADE_W'(1);
        end
    end

    // restoring divider step
    assign rem2   = {r_rem[DEN_W-2:0], 1'b0};
    assign div_ge = rem2 >= DEN_W'(r_den);

    // screen cell
    assign pos_x = r_xs[SCREEN_SHIFT +: XW];
    assign pos_y = r_ys[SCREEN_SHIFT +: YW];
    assign x_ok  = ($signed(r_xs[ACC_W-1:SCREEN_SHIFT]) > 34'sd0)
                && ($signed(r_xs[ACC_W-1:SCREEN_SHIFT]) < 34'(COLUMNS));
    assign y_ok  = ($signed(r_ys[ACC_W-1:SCREEN_SHIFT]) > 34'sd0)
                && ($signed(r_ys[ACC_W-1:SCREEN_SHIFT]) < 34'(ROWS));
    assign hit   = x_ok && y_ok;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = i_cmd ? S_READ : S_MATH;
                end
            end
            S_MATH: begin
                if (r_step == 4'd15) begin
                    if (r_den <= 0) begin
                        n_state = S_IDLE;
                    end else if (r_den <= (DEN_W'(1) <<< DEN_SHIFT)) begin
                        n_state = S_PROJ;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (r_step == 4'd15) begin
                    n_state = S_PROJ;
                end
            end
            S_PROJ: begin
                if (r_step == 4'd4) begin
                    n_state = hit ? S_READ : S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (!r_cmd || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_stall   = 1'b1;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            S_READ: begin
                ram_re = 1'b1;
            end
            S_UPDATE: begin
                if (r_cmd) begin
                    ram_we = r_inrange && out_free;
                end else begin
                    ram_we          = r_d > ram_rdata.depth;
                    ram_wdata.depth = r_d;
                    ram_wdata.shade = r_shade;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == S_UPDATE && r_cmd && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state != n_state) begin
            r_step <= '0;
        end else begin
            r_step <= r_step + STEP_W'(1);
        end

        if (accept) begin
            r_cmd     <= i_cmd;
            r_st      <= i_sin_tube;
            r_ct      <= i_cos_tube;
            r_sr      <= i_sin_ring;
            r_cr      <= i_cos_ring;
            r_h       <= HALF_W'(i_cos_tube) + HALF_W'(TUBE_OFFSET <<< FRAC_BITS);
            r_addr    <= idx_ext[AW-1:0];
            r_inrange <= idx_ext < IW'(CELLS);
        end

        case (r_state)
            S_MATH: begin
                case (r_step)
                    4'd0:  r_ta  <= TMP_W'(mul_p);
                    4'd1:  r_tb  <= PROD_W'(mul_p);
                    4'd2:  r_tc  <= PROD_W'(mul_p);
                    4'd3:  r_den <= alu[DEN_W-1:0];
                    4'd4:  r_t   <= alu[TMP_W-1:0];
                    4'd5:  r_te  <= TMP_W'(mul_p);
                    4'd6:  r_acc <= alu;
                    4'd7:  r_px  <= alu[POS_W-1:0];
                    4'd8:  r_acc <= alu;
                    4'd9:  r_py  <= alu[POS_W-1:0];
                    4'd10: r_ta  <= TMP_W'(mul_p);
                    4'd11: r_t   <= alu[TMP_W-1:0];
                    4'd12: r_acc <= alu;
                    4'd13: r_acc <= alu;
                    4'd14: r_te  <= TMP_W'(mul_p);
                    default: begin
                        r_shade <= shade_n;
                        r_rem   <= DEN_W'(1) << DEN_SHIFT;
                        r_d     <= '1;
                    end
                endcase
            end
            S_DIV: begin
                r_rem <= div_ge ? (rem2 - DEN_W'(r_den)) : rem2;
                r_d   <= {r_d[RECIP_BITS-2:0], div_ge};
            end
            S_PROJ: begin
                case (r_step)
                    4'd0:    r_sd   <= mul_p[SCALED_W-1:0];
                    4'd1:    r_xs   <= alu;
                    4'd2:    r_sd   <= mul_p[SCALED_W-1:0];
                    4'd3:    r_ys   <= alu;
                    default: r_addr <= mul_p[AW-1:0] + AW'(pos_x);
                endcase
            end
            S_UPDATE: begin
                if (r_cmd && out_free) begin
                    r_oglyph <= r_inrange ? glyph_of(ram_rdata.shade) : GLYPH_SPACE;
                end
            end
            default: ;
        endcase
    end

    tpz_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rword)
    );

    assign ram_rdata = t_cell'(ram_rword);
    assign o_valid   = r_ovalid;
    assign o_glyph   = r_oglyph;

`ifndef SYNTHESIS
    a_glyph_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_UPDATE))
        else $error("glyph appeared outside the store cycle");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("store written while idle");

    a_plot_starts_math: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_cmd) |=> (r_state == S_MATH) && (r_step == '0))
        else $error("plot request did not start the math sequence");

    a_div_to_proj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == 4'd15) |=> (r_state == S_PROJ))
        else $error("divider did not hand over to projection");
`endif

endmodule

>>> test/tb_torus_point_zbuffer_plot_core.sv
module tb_torus_point_zbuffer_plot_core;
    import tpz_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 40;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam bit CMD_PLOT = 1'b0;
    localparam bit CMD_READ = 1'b1;

    typedef struct {
        bit                      cmd;
        logic signed [TRIG_W-1:0] st;
        logic signed [TRIG_W-1:0] ct;
        logic signed [TRIG_W-1:0] sr;
        logic signed [TRIG_W-1:0] cr;
        logic [11:0]             idx;
    } t_req;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_cmd = 1'b0;
    logic signed [TRIG_W-1:0] i_sin_tube = '0;
    logic signed [TRIG_W-1:0] i_cos_tube = '0;
    logic signed [TRIG_W-1:0] i_sin_ring = '0;
    logic signed [TRIG_W-1:0] i_cos_ring = '0;
    logic [11:0]              i_cell_index = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [GLYPH_W-1:0]       o_glyph;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_AW-1:0]        paddr = '0;
    logic [CFG_DW-1:0]        pwdata = '0;
    logic [CFG_DW-1:0]        prdata;
    logic                     pready;

    torus_point_zbuffer_plot_core #(.COLUMNS(COLUMNS), .ROWS(ROWS)) i_dut (.*);

    // predictor state
    logic signed [TRIG_W-1:0] rot_sa = 0, rot_ca = 16384, rot_sb = 0, rot_cb = 16384;
    logic [SCALE_W-1:0]       scl_h = 40, scl_v = 20;
    bit [DEPTH_W-1:0]         zdepth [CELLS];
    bit [SHADE_W-1:0]         zshade [CELLS];
    string                    ramp = ".,-~:;=!*#$@";

    t_req        pending_reqs[$];
    logic [7:0]  glyphs_due[$];
    int          lit_cells[$];
    bit          rst_done = 0, calm = 0;
    int          idle_pct = 25;
    int          n_accepted = 0, n_sent = 0, n_plots = 0, n_reads = 0, n_glyphs = 0;
    int          n_stored = 0, n_errors = 0, gap_left = 0, stall_left = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint sx(logic signed [TRIG_W-1:0] v);
        return longint'(v);
    endfunction

    function automatic void plot_point(t_req r);
        longint st, ct, sr, cr, sa, ca, sb, cb, h, den, d, t, px, py, xs, ys, x, y, q, lum, n;
        longint one;
        int slot;
        one = 1;
        st = sx(r.st); ct = sx(r.ct); sr = sx(r.sr); cr = sx(r.cr);
        sa = sx(rot_sa); ca = sx(rot_ca); sb = sx(rot_sb); cb = sx(rot_cb);
        h = ct + 2 * 16384;
        den = sr * h * sa + st * ca * 16384 + (5 * (one <<< 42));
        if (den <= 0) return;
        d = (one <<< 58) / den;
        if (d > 65535) d = 65535;
        t = (sr * h * ca - st * sa * 16384) >>> 14;
        px = (cr * h * cb - t * sb) >>> 28;
        py = (cr * h * sb + t * cb) >>> 28;
        xs = COLUMNS * (one <<< 29) + longint'(scl_h) * d * px;
        ys = ROWS * (one <<< 29) + longint'(scl_v) * d * py;
        x = xs / (one <<< 30);
        y = ys / (one <<< 30);
        q = (st * sa * 16384 - sr * ct * ca) >>> 14;
        lum = q * cb - sr * ct * sa - st * ca * 16384 - cr * ct * sb;
        n = (lum * 8) / (one <<< 42);
        if (n < 0) n = 0;
        if (n > 11) n = 11;
        if (x <= 0 || x >= COLUMNS || y <= 0 || y >= ROWS) return;
        slot = int'(x + COLUMNS * y);
        if (d > longint'(zdepth[slot])) begin
            zdepth[slot] = d[15:0];
            zshade[slot] = n[3:0] + 4'd1;
            lit_cells.push_back(slot);
            n_stored++;
        end
    endfunction

    function automatic logic [7:0] read_cell(logic [11:0] idx);
        logic [7:0] g;
        g = 8'd32;
        if (idx < CELLS) begin
            if (zshade[idx] >= 1 && zshade[idx] <= 12) g = ramp[zshade[idx] - 1];
            zshade[idx] = 0;
            zdepth[idx] = 0;
        end
        return g;
    endfunction

    // request side
    always @(posedge i_clk) begin
        if (rst_done && i_valid && !o_stall) begin
            t_req r;
            r.cmd = i_cmd; r.st = i_sin_tube; r.ct = i_cos_tube;
            r.sr = i_sin_ring; r.cr = i_cos_ring; r.idx = i_cell_index;
            n_accepted <= n_accepted + 1;
            if (r.cmd == CMD_PLOT) begin
                plot_point(r);
                n_plots++;
            end else begin
                glyphs_due.push_back(read_cell(r.idx));
                n_reads++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (rst_done && !(i_valid && n_accepted < n_sent)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
                gap_left <= $urandom_range(0, 3);
                i_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                t_req r;
                r = pending_reqs.pop_front();
                i_valid <= 1'b1;
                i_cmd <= r.cmd;
                i_sin_tube <= r.st; i_cos_tube <= r.ct;
                i_sin_ring <= r.sr; i_cos_ring <= r.cr;
                i_cell_index <= r.idx;
                n_sent <= n_sent + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(negedge i_clk) begin
        if (calm) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left <= $urandom_range(0, 3);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (rst_done && o_valid && !i_stall) begin
            n_glyphs++;
            if (glyphs_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected glyph %0d", o_glyph);
            end else begin
                logic [7:0] g;
                g = glyphs_due.pop_front();
                if (o_glyph !== g) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("glyph mismatch: expected %0d got %0d", g, o_glyph);
                end
            end
        end
    end

    task automatic apb_write(t_reg r, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= CFG_AW'(4 * int'(r)); pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            REG_SIN_ROT_A:   rot_sa = v[15:0];
            REG_COS_ROT_A:   rot_ca = v[15:0];
            REG_SIN_ROT_B:   rot_sb = v[15:0];
            REG_COS_ROT_B:   rot_cb = v[15:0];
            REG_SCALE_HORIZ: scl_h = v[7:0];
            default:         scl_v = v[7:0];
        endcase
    endtask

    task automatic set_frame(int sa, int ca, int sb, int cb, int sh, int sv);
        apb_write(REG_SIN_ROT_A, 32'(sa));
        apb_write(REG_COS_ROT_A, 32'(ca));
        apb_write(REG_SIN_ROT_B, 32'(sb));
        apb_write(REG_COS_ROT_B, 32'(cb));
        apb_write(REG_SCALE_HORIZ, 32'(sh));
        apb_write(REG_SCALE_VERT, 32'(sv));
    endtask

    // nothing left to send, nothing in flight, no glyph outstanding
    task automatic drain();
        do @(posedge i_clk);
        while (!(pending_reqs.size() == 0 && !i_valid && !o_stall && glyphs_due.size() == 0));
        repeat (60) @(posedge i_clk);
    endtask

    function automatic int q14(real v);
        return $rtoi(v * 16384.0);
    endfunction

    task automatic push(bit cmd, int st, int ct, int sr, int cr, int idx);
        t_req r;
        r.cmd = cmd; r.st = st[15:0]; r.ct = ct[15:0]; r.sr = sr[15:0]; r.cr = cr[15:0];
        r.idx = idx[11:0];
        wait (pending_reqs.size() < 2);
        pending_reqs.push_back(r);
    endtask

    task automatic push_point();
        real a, b;
        a = $urandom_range(0, 62831) / 10000.0;
        b = $urandom_range(0, 62831) / 10000.0;
        push(CMD_PLOT, q14($sin(a)), q14($cos(a)), q14($sin(b)), q14($cos(b)), 0);
    endtask

    task automatic push_read();
        int c;
        c = $urandom_range(0, 99);
        if (c < 60 && lit_cells.size() > 0)
            push(CMD_READ, 0, 0, 0, 0, lit_cells[$urandom_range(0, lit_cells.size() - 1)]);
        else if (c < 90)
            push(CMD_READ, 0, 0, 0, 0, $urandom_range(0, CELLS - 1));
        else
            push(CMD_READ, 0, 0, 0, 0, $urandom_range(CELLS, 4095));
    endtask

    task automatic push_noise();
        push($urandom_range(0, 1), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom_range(0, 4095));
    endtask

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++) begin
            int c;
            c = $urandom_range(0, 99);
            if (c < 60) push_point();
            else if (c < 90) push_read();
            else push_noise();
        end
    endtask

    initial begin
        real a, b;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        rst_done <= 1'b1;

        // directed: field extremes, ties, reads at the ends of the store
        push(CMD_READ, 0, 0, 0, 0, 0);
        push(CMD_PLOT, 0, 16384, 0, 16384, 0);
        push(CMD_PLOT, 0, 16384, 0, 16384, 0);
        push(CMD_READ, 0, 0, 0, 0, 40 + 80 * 20 + 26);
        push(CMD_PLOT, 16384, 0, 0, 16384, 0);
        push(CMD_PLOT, -16384, 0, 0, -16384, 0);
        push(CMD_PLOT, 0, -16384, 16384, 0, 0);
        push(CMD_PLOT, 0, -16384, -16384, 0, 0);
        push(CMD_PLOT, -16384, -16384, -16384, -16384, 0);
        push(CMD_PLOT, 16384, 16384, 16384, 16384, 0);
        push(CMD_PLOT, -32768, 32767, -32768, 32767, 0);
        push(CMD_PLOT, 32767, -32768, 32767, -32768, 0);
        push(CMD_PLOT, -32768, -32768, -32768, -32768, 0);
        push(CMD_READ, 0, 0, 0, 0, CELLS - 1);
        push(CMD_READ, 0, 0, 0, 0, CELLS);
        push(CMD_READ, 0, 0, 0, 0, 4095);
        for (int k = 0; k < 5; k++) push_point();
        for (int k = 0; k < 4; k++) push_read();
        drain();

        // saturating reciprocal depth
        set_frame(16384, 16384, 0, 16384, 255, 255);
        push(CMD_PLOT, -16384, 16384, -16384, 16384, 0);
        push(CMD_PLOT, -16384, 16384, -16384, -16384, 0);
        random_phase(90);
        drain();

        for (int p = 0; p < 6; p++) begin
            a = $urandom_range(0, 62831) / 10000.0;
            b = $urandom_range(0, 62831) / 10000.0;
            case (p)
                0: set_frame(-16384, 16384, 16384, -16384, 0, 0);
                1: set_frame(q14($sin(a)), q14($cos(a)), q14($sin(b)), q14($cos(b)), 255, 0);
                default: set_frame(q14($sin(a)), q14($cos(a)), q14($sin(b)), q14($cos(b)),
                                   $urandom_range(20, 70), $urandom_range(10, 35));
            endcase
            idle_pct = (p == 2) ? 0 : $urandom_range(10, 40);
            if (p == 5) calm = 1;
            random_phase(115);
            if (p < 5) drain();
        end

        drain();
        $display("%0d requests (%0d plots, %0d reads), %0d cells written, %0d glyphs checked",
                 n_accepted, n_plots, n_reads, n_stored, n_glyphs);
        if (n_errors == 0 && glyphs_due.size() == 0) begin
            $display("tb_torus_point_zbuffer_plot_core passed");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("tb_torus_point_zbuffer_plot_core failed");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("timeout");
        $display("tb_torus_point_zbuffer_plot_core failed");
        $finish;
    end

endmodule
